>>> sv/sgr_pkg.sv
// Shared types and constants for the stream group reverser.
package sgr_pkg;

  localparam int MAX_GROUP_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 5'd4;

  typedef struct packed {
    logic bank;
    logic reverse;
    logic eol;
  } cmd_flags_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

endpackage

>>> sv/stream_group_reverser.sv
// Stream group reverser top level: stream ports, front end, command queue, back end.
//
// Words arrive on the s_ side and fill one of two banks of MAX_GROUP words. Once the
// bank holds group_size words it is drained newest first; an end of list that finds a
// partial group drains it in arrival order. m_tlast marks the last word of each run and
// m_tuser the last word of the list. The front end takes at most one word per cycle while
// the back end drains the other bank through its single read port; a bank frees only
// when its last word is read. The first word of a run passes through the command queue,
// the back end's run registers, its read register and the output register to m_tvalid;
// s_tready drops while the bank to be filled next is still draining. The group size
// register is 5 bits, reset 4; zero acts as one and values above MAX_GROUP as MAX_GROUP.
module stream_group_reverser #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF,
  parameter int WORD_BITS = sgr_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [sgr_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [((WORD_BITS+7)/8)*8-1:0] s_tdata,   // word_value
  input  logic                          s_tlast,   // end_of_list
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [((WORD_BITS+7)/8)*8-1:0] m_tdata,   // out_value
  output logic                          m_tlast,   // run_last
  output logic [0:0]                    m_tuser    // list_last
);

  localparam int CNT_W  = $clog2(MAX_GROUP + 1);
  localparam int IDX_W  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int TD_W   = ((WORD_BITS + 7) / 8) * 8;
  localparam int FLAG_W = $bits(sgr_pkg::cmd_flags_t);
  localparam int CMD_W  = FLAG_W + CNT_W;

  logic                   wr_en;
  logic [IDX_W:0]         wr_addr;
  logic [WORD_BITS-1:0]   wr_data;
  logic                   cmd_push;
  logic                   cmd_push_ready;
  sgr_pkg::cmd_flags_t    front_flags;
  logic [CNT_W-1:0]       front_count;
  logic                   cmd_valid;
  logic                   cmd_pop;
  logic [CMD_W-1:0]       cmd_data;
  sgr_pkg::cmd_flags_t    back_flags;
  logic [CNT_W-1:0]       back_count;
  sgr_pkg::bank_release_t release_bank;
  logic [WORD_BITS-1:0]   out_value;
  logic                   out_list_last;

  sgr_front #(
    .MAX_GROUP (MAX_GROUP),
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_word     (s_tdata[WORD_BITS-1:0]),
    .in_eol      (s_tlast),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .cmd_valid   (cmd_push),
    .cmd_ready   (cmd_push_ready),
    .cmd_flags   (front_flags),
    .cmd_count   (front_count),
    .release_in  (release_bank)
  );

  sgr_cmd_fifo #(
    .DATA_W (CMD_W)
  ) u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_ready (cmd_push_ready),
    .push_data  ({front_flags, front_count}),
    .pop_valid  (cmd_valid),
    .pop        (cmd_pop),
    .pop_data   (cmd_data)
  );

  assign back_flags = sgr_pkg::cmd_flags_t'(cmd_data[CMD_W-1:CNT_W]);
  assign back_count = cmd_data[CNT_W-1:0];

  sgr_back #(
    .MAX_GROUP (MAX_GROUP),
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop),
    .cmd_flags     (back_flags),
    .cmd_count     (back_count),
    .release_out   (release_bank),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_value     (out_value),
    .out_run_last  (m_tlast),
    .out_list_last (out_list_last)
  );

  assign m_tdata    = TD_W'(out_value);
  assign m_tuser[0] = out_list_last;

endmodule

>>> sv/sgr_front.sv
// Front end: accepts words, fills the ping-pong banks and issues drain commands.
module sgr_front #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF,
  parameter int WORD_BITS = sgr_pkg::WORD_BITS_DEF,
  parameter int CNT_W     = $clog2(MAX_GROUP + 1),
  parameter int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [sgr_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [WORD_BITS-1:0]    in_word,
  input  logic                    in_eol,
  output logic                    wr_en,
  output logic [IDX_W:0]          wr_addr,
  output logic [WORD_BITS-1:0]    wr_data,
  output logic                    cmd_valid,
  input  logic                    cmd_ready,
  output sgr_pkg::cmd_flags_t     cmd_flags,
  output logic [CNT_W-1:0]        cmd_count,
  input  sgr_pkg::bank_release_t  release_in
);

  localparam int LIM_W = (CNT_W > sgr_pkg::CFG_W) ? CNT_W : sgr_pkg::CFG_W;
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_GROUP);

  logic [sgr_pkg::CFG_W-1:0] group_size;
  logic [CNT_W-1:0]          fill;
  logic                      bank;
  logic [1:0]                busy;
  logic [1:0]                busy_next;

  logic [LIM_W-1:0] size_ext;
  logic [LIM_W-1:0] limit;
  logic [CNT_W-1:0] fill_inc;
  logic             accept;
  logic             full_group;
  logic             emit;

  always_comb begin
    size_ext = LIM_W'(group_size);
    if (size_ext == '0) begin
      limit = LIM_W'(1);
    end else if (size_ext > MAX_LIM) begin
      limit = MAX_LIM;
    end else begin
      limit = size_ext;
    end
  end

  assign in_ready   = !busy[bank] && cmd_ready;
  assign accept     = in_valid && in_ready;
  assign fill_inc   = fill + CNT_W'(1);
  assign full_group = LIM_W'(fill_inc) >= limit;
  assign emit       = accept && (full_group || in_eol);

  assign wr_en   = accept;
  assign wr_addr = {bank, fill[IDX_W-1:0]};
  assign wr_data = in_word;

  assign cmd_valid         = emit;
  assign cmd_flags.bank    = bank;
  assign cmd_flags.reverse = full_group;
  assign cmd_flags.eol     = in_eol;
  assign cmd_count         = fill_inc;

  always_comb begin
    busy_next = busy;
    if (emit) begin
      busy_next[bank] = 1'b1;
    end
    if (release_in.valid) begin
      busy_next[release_in.bank] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= sgr_pkg::GROUP_SIZE_RESET;
    end else if (cfg_wr_en) begin
      group_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bank <= 1'b0;
      busy <= 2'b00;
    end else begin
      if (accept) begin
        if (emit) begin
          fill <= '0;
          bank <= !bank;
        end else begin
          fill <= fill_inc;
        end
      end
      busy <= busy_next;
    end
  end

endmodule

>>> sv/sgr_cmd_fifo.sv
// Two-entry command queue between the front and back ends.
module sgr_cmd_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] entry [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  logic do_push;
  logic do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/sgr_back.sv
// Back end: holds the bank memory and drains runs to the output register.
module sgr_back #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF,
  parameter int WORD_BITS = sgr_pkg::WORD_BITS_DEF,
  parameter int CNT_W     = $clog2(MAX_GROUP + 1),
  parameter int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [IDX_W:0]         wr_addr,
  input  logic [WORD_BITS-1:0]   wr_data,
  input  logic                   cmd_valid,
  output logic                   cmd_pop,
  input  sgr_pkg::cmd_flags_t    cmd_flags,
  input  logic [CNT_W-1:0]       cmd_count,
  output sgr_pkg::bank_release_t release_out,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [WORD_BITS-1:0]   out_value,
  output logic                   out_run_last,
  output logic                   out_list_last
);

  localparam int DEPTH = 2 << IDX_W;

  logic [WORD_BITS-1:0] mem [DEPTH];

  logic             active;
  logic             bank;
  logic             reverse;
  logic             eol;
  logic [CNT_W-1:0] left;
  logic [IDX_W-1:0] pos;

  logic                 rd_valid;
  logic                 rd_run_last;
  logic                 rd_list_last;
  logic [WORD_BITS-1:0] rd_data;

  logic issue;
  logic last_issue;
  logic move;

  assign move       = rd_valid && (!out_valid || out_ready);
  assign issue      = active && (!rd_valid || move);
  assign last_issue = issue && (left == CNT_W'(1));
  assign cmd_pop    = cmd_valid && (!active || last_issue);

  assign release_out.valid = last_issue;
  assign release_out.bank  = bank;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[{bank, pos}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd_pop) begin
      active <= 1'b1;
    end else if (last_issue) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      bank    <= cmd_flags.bank;
      reverse <= cmd_flags.reverse;
      eol     <= cmd_flags.eol;
      left    <= cmd_count;
      if (cmd_flags.reverse) begin
        pos <= IDX_W'(cmd_count - CNT_W'(1));
      end else begin
        pos <= '0;
      end
    end else if (issue) begin
      left <= left - CNT_W'(1);
      if (reverse) begin
        pos <= pos - IDX_W'(1);
      end else begin
        pos <= pos + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (issue) begin
      rd_valid <= 1'b1;
    end else if (move) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_run_last  <= last_issue;
      rd_list_last <= last_issue && eol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_value     <= rd_data;
      out_run_last  <= rd_run_last;
      out_list_last <= rd_list_last;
    end
  end

endmodule
